### rtl/core/mfb_pkg.sv
// Shared types and constants for the monochrome framebuffer rectangle-fill block.
// Used by the controller, the datapath and the top level; depends on nothing else.
package mfb_pkg;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PHYS_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PHYS_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PORTRAIT    = 2'd2;

   localparam int CSR_DATA_W = 9;
   localparam logic [CSR_DATA_W-1:0] PHYS_WIDTH_RST  = 9'd200;
   localparam logic [CSR_DATA_W-1:0] PHYS_HEIGHT_RST = 9'd200;

   // Request type codes.
   localparam logic REQ_FILL = 1'b0;
   localparam logic REQ_READ = 1'b1;

   // Bit mask of the leftmost pixel in a framebuffer byte.
   localparam logic [7:0] PIX_MASK_MSB = 8'h80;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_START,
      ST_CALC,
      ST_READ,
      ST_WRITE,
      ST_FETCH,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear;     // write one zero byte of the clearing pass
      logic start;     // accept a transaction and latch its fields
      logic calc;      // compute address and mask of the current pixel
      logic rd_fill;   // read the byte of the current pixel
      logic wr_fill;   // write back the modified byte and step the walk
      logic fetch;     // read the byte of a read request
      logic deliver;   // load the result register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clr_last;
      logic is_read;
      logic empty;
      logic last_pixel;
      logic out_free;
   } stat_type;

endpackage

### rtl/core/mfb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stands alone; no package dependency.
module mfb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/mfb_ctrl.sv
// Controller state machine for the framebuffer block: clearing pass, request
// dispatch, per-pixel read-modify-write sequencing. Uses mfb_pkg.
module mfb_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  mfb_pkg::stat_type  stat,
   output mfb_pkg::cmd_type   cmd
);

   mfb_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mfb_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mfb_pkg::ST_CLEAR: begin
            if (stat.clr_last) state_in = mfb_pkg::ST_IDLE;
         end
         mfb_pkg::ST_IDLE: begin
            if (req_valid) state_in = mfb_pkg::ST_START;
         end
         mfb_pkg::ST_START: begin
            if (stat.is_read)    state_in = mfb_pkg::ST_FETCH;
            else if (stat.empty) state_in = mfb_pkg::ST_DONE;
            else                 state_in = mfb_pkg::ST_CALC;
         end
         mfb_pkg::ST_CALC:  state_in = mfb_pkg::ST_READ;
         mfb_pkg::ST_READ:  state_in = mfb_pkg::ST_WRITE;
         mfb_pkg::ST_WRITE: begin
            state_in = stat.last_pixel ? mfb_pkg::ST_DONE : mfb_pkg::ST_CALC;
         end
         mfb_pkg::ST_FETCH: state_in = mfb_pkg::ST_DONE;
         mfb_pkg::ST_DONE: begin
            if (stat.out_free) state_in = mfb_pkg::ST_IDLE;
         end
         default: state_in = mfb_pkg::ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         mfb_pkg::ST_CLEAR: cmd.clear = 1'b1;
         mfb_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.start = req_valid;
         end
         mfb_pkg::ST_CALC:  cmd.calc    = 1'b1;
         mfb_pkg::ST_READ:  cmd.rd_fill = 1'b1;
         mfb_pkg::ST_WRITE: cmd.wr_fill = 1'b1;
         mfb_pkg::ST_FETCH: cmd.fetch   = 1'b1;
         mfb_pkg::ST_DONE:  cmd.deliver = stat.out_free;
         default: ;
      endcase
   end

endmodule

### rtl/core/mfb_dpath.sv
// Datapath of the framebuffer block: configuration registers, clamping, pixel
// walk, address mapping, framebuffer RAM and result register. Uses mfb_pkg, mfb_ram.
module mfb_dpath #(
   parameter int MAX_DIM     = 256,
   parameter int STORE_BYTES = 8192
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [mfb_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [mfb_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                              req_type,
   input  logic [7:0]                        req_x_start,
   input  logic [7:0]                        req_x_end,
   input  logic [7:0]                        req_y_start,
   input  logic [7:0]                        req_y_end,
   input  logic [15:0]                       req_colour,
   input  logic [12:0]                       req_byte_index,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [7:0]                        rsp_read_data,
   output logic                              rsp_done_res,
   input  mfb_pkg::cmd_type                  cmd,
   output mfb_pkg::stat_type                 stat
);

   localparam int DW  = $clog2(MAX_DIM + 1);
   localparam int RBW = DW - 2;
   localparam int AW  = $clog2(STORE_BYTES);
   localparam int SW  = $clog2(STORE_BYTES + 1);
   localparam int VW  = (DW > mfb_pkg::CSR_DATA_W) ? DW : mfb_pkg::CSR_DATA_W;
   localparam int CW  = (DW > 8) ? DW : 8;
   localparam int XW0 = (2 * DW - 1 > SW) ? 2 * DW - 1 : SW;
   localparam int XW  = (XW0 > 13) ? XW0 : 13;

   // Configuration registers.
   logic [mfb_pkg::CSR_DATA_W-1:0] width_ff, height_ff;
   logic                           portrait_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= mfb_pkg::PHYS_WIDTH_RST;
         height_ff   <= mfb_pkg::PHYS_HEIGHT_RST;
         portrait_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            mfb_pkg::CSR_PHYS_WIDTH:  width_ff    <= csr_wdata;
            mfb_pkg::CSR_PHYS_HEIGHT: height_ff   <= csr_wdata;
            mfb_pkg::CSR_PORTRAIT:    portrait_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Effective panel size: zero acts as one, above the maximum acts as the maximum.
   logic [VW-1:0] w_ext, h_ext;
   logic [DW-1:0] pw_eff, ph_eff, lw, lh;
   logic [DW:0]   rowb_sum;

   assign w_ext    = VW'(width_ff);
   assign h_ext    = VW'(height_ff);
   assign pw_eff   = (w_ext == '0) ? DW'(1) :
                     (w_ext > VW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(w_ext);
   assign ph_eff   = (h_ext == '0) ? DW'(1) :
                     (h_ext > VW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(h_ext);
   assign lw       = portrait_ff ? ph_eff : pw_eff;
   assign lh       = portrait_ff ? pw_eff : ph_eff;
   assign rowb_sum = (DW + 1)'(pw_eff) + (DW + 1)'(7);

   // Corner clamping against the logical size.
   logic [CW-1:0] lw_ext, lh_ext;
   logic [DW-1:0] sx_c, ex_c, sy_c, ey_c;

   assign lw_ext = CW'(lw);
   assign lh_ext = CW'(lh);
   assign sx_c = (CW'(req_x_start) >= lw_ext) ? DW'(lw_ext - CW'(1)) : DW'(req_x_start);
   assign ex_c = (CW'(req_x_end)   >= lw_ext) ? DW'(lw_ext - CW'(1)) : DW'(req_x_end);
   assign sy_c = (CW'(req_y_start) >= lh_ext) ? DW'(lh_ext - CW'(1)) : DW'(req_y_start);
   assign ey_c = (CW'(req_y_end)   >= lh_ext) ? DW'(lh_ext - CW'(1)) : DW'(req_y_end);

   // Transaction registers, latched on acceptance.
   logic           is_read_ff, set_ff, rot_ff;
   logic [DW-1:0]  sx_ff, ex_ff, sy_ff, ey_ff, pw_ff, ph_ff;
   logic [RBW-1:0] rowb_ff;
   logic [12:0]    byte_index_ff;
   logic [DW-1:0]  col_ff, row_ff;

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         is_read_ff    <= (req_type == mfb_pkg::REQ_READ);
         set_ff        <= (req_colour != 16'd0);
         rot_ff        <= portrait_ff;
         sx_ff         <= sx_c;
         ex_ff         <= ex_c;
         sy_ff         <= sy_c;
         ey_ff         <= ey_c;
         pw_ff         <= pw_eff;
         ph_ff         <= ph_eff;
         rowb_ff       <= rowb_sum[DW:3];
         byte_index_ff <= req_byte_index;
         col_ff        <= sx_c;
         row_ff        <= sy_c;
      end else if (cmd.wr_fill) begin
         // Raster walk: columns inside rows.
         if (col_ff == ex_ff) begin
            col_ff <= sx_ff;
            row_ff <= row_ff + DW'(1);
         end else begin
            col_ff <= col_ff + DW'(1);
         end
      end
   end

   // Mapping of the current pixel to a byte address and bit mask.
   logic [DW-1:0] px, py, prow;
   logic [XW-1:0] full_addr;
   logic [AW-1:0] addr_ff;
   logic [7:0]    mask_ff;
   logic          inrange_ff;

   assign px   = rot_ff ? (pw_ff - DW'(1) - row_ff) : col_ff;
   assign py   = rot_ff ? col_ff : row_ff;
   assign prow = ph_ff - DW'(1) - py;
   assign full_addr = XW'(prow) * XW'(rowb_ff) + XW'(px[DW-1:3]);

   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         addr_ff    <= full_addr[AW-1:0];
         mask_ff    <= mfb_pkg::PIX_MASK_MSB >> px[2:0];
         inrange_ff <= (full_addr < XW'(STORE_BYTES));
      end
   end

   // Clearing pass after reset.
   logic [AW-1:0] clr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear) begin
         clr_ff <= clr_ff + AW'(1);
      end
   end

   // Framebuffer store.
   logic [XW-1:0] bi_ext;
   logic          rd_inrange;
   logic          ram_wr_en, ram_rd_en;
   logic [AW-1:0] ram_wr_addr, ram_rd_addr;
   logic [7:0]    ram_wr_data, ram_rd_data;

   assign bi_ext      = XW'(byte_index_ff);
   assign rd_inrange  = (bi_ext < XW'(STORE_BYTES));
   assign ram_wr_en   = cmd.clear | (cmd.wr_fill & inrange_ff);
   assign ram_wr_addr = cmd.clear ? clr_ff : addr_ff;
   assign ram_wr_data = cmd.clear ? 8'd0 :
                        set_ff ? (ram_rd_data | mask_ff) : (ram_rd_data & ~mask_ff);
   assign ram_rd_en   = cmd.rd_fill | cmd.fetch;
   assign ram_rd_addr = cmd.fetch ? bi_ext[AW-1:0] : addr_ff;

   mfb_ram #(
      .WIDTH (8),
      .DEPTH (STORE_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Result register; it frees up in the cycle the receiver takes its transaction.
   logic       rsp_valid_ff;
   logic [7:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.deliver) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.deliver) begin
         rsp_data_ff <= (is_read_ff && rd_inrange) ? ram_rd_data : 8'd0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;
   assign rsp_done_res  = 1'b1;

   assign stat.clr_last   = (clr_ff == AW'(STORE_BYTES - 1));
   assign stat.is_read    = is_read_ff;
   assign stat.empty      = (sx_ff > ex_ff) || (sy_ff > ey_ff);
   assign stat.last_pixel = (col_ff == ex_ff) && (row_ff == ey_ff);
   assign stat.out_free   = ~rsp_valid_ff | rsp_ready;

endmodule

### rtl/core/mono_framebuffer_rect_fill.sv
// Monochrome e-paper framebuffer, 1 bit per pixel, with rectangle fill and byte read.
// Top level: joins mfb_ctrl and mfb_dpath; uses mfb_pkg.
//
// Requests arrive on the req_ valid/ready channel: req_type selects a rectangle fill
// (corners clamped to the logical size, bits set for any non-black colour, cleared for
// black) or a read of one framebuffer byte at req_byte_index. Each transaction gives
// exactly one result on the rsp_ valid/ready channel: the byte for a read, zero after a
// fill, with rsp_done_res always high. Panel size and orientation are written through
// the csr_ port; the user writes them only while the block is idle (not enforced).
// Requests are handled one at a time. A read passes through the start, fetch and done
// states before rsp_valid rises. A fill passes through start, then for each pixel of the
// clamped rectangle an address calculation, a registered read of the framebuffer store
// and a write-back of the modified byte, then done; an empty one goes from start to done.
// The block returns to idle as the result is loaded, so a new request can be taken once
// the previous result is loaded. After reset the store is swept to zero, one byte per
// cycle, over all STORE_BYTES bytes (8192 by default); req_ready stays low meanwhile,
// configuration writes are taken. A result waits in an output register while the
// receiver stalls; the next request is accepted meanwhile and its own result waits
// until that register is taken.
module mono_framebuffer_rect_fill #(
   parameter int MAX_DIM     = 256,
   parameter int STORE_BYTES = 8192
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [mfb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mfb_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_type,
   input  logic [7:0]                      req_x_start,
   input  logic [7:0]                      req_x_end,
   input  logic [7:0]                      req_y_start,
   input  logic [7:0]                      req_y_end,
   input  logic [15:0]                     req_colour,
   input  logic [12:0]                     req_byte_index,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [7:0]                      rsp_read_data,
   output logic                            rsp_done_res
);

   mfb_pkg::cmd_type  cmd;
   mfb_pkg::stat_type stat;

   mfb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   mfb_dpath #(
      .MAX_DIM     (MAX_DIM),
      .STORE_BYTES (STORE_BYTES)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_type       (req_type),
      .req_x_start    (req_x_start),
      .req_x_end      (req_x_end),
      .req_y_start    (req_y_start),
      .req_y_end      (req_y_end),
      .req_colour     (req_colour),
      .req_byte_index (req_byte_index),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_data  (rsp_read_data),
      .rsp_done_res   (rsp_done_res),
      .cmd            (cmd),
      .stat           (stat)
   );

endmodule

### tb/tb_mono_framebuffer_rect_fill.sv
`timescale 1ns / 100ps
// Self-checking testbench for mono_framebuffer_rect_fill: fills and byte reads are predicted
// against a local 1-bit-per-pixel frame model and checked per transaction. Needs mfb_pkg.
module tb_mono_framebuffer_rect_fill;

   localparam int FB_BYTES    = 8192;
   localparam int PANEL_MAX   = 256;
   localparam int STALL_LEN   = 300;
   localparam int SETTLE      = 12;
   localparam int CYCLE_LIMIT = 5_000_000;
   localparam int PER_PHASE   = 95;
   localparam logic [mfb_pkg::CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct {
      logic        kind;
      logic [7:0]  x_start;
      logic [7:0]  x_end;
      logic [7:0]  y_start;
      logic [7:0]  y_end;
      logic [15:0] colour;
      logic [12:0] byte_index;
   } fb_request_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            csr_we = 1'b0;
   logic [mfb_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [mfb_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic                            req_type = mfb_pkg::REQ_FILL;
   logic [7:0]                      req_x_start = '0;
   logic [7:0]                      req_x_end = '0;
   logic [7:0]                      req_y_start = '0;
   logic [7:0]                      req_y_end = '0;
   logic [15:0]                     req_colour = '0;
   logic [12:0]                     req_byte_index = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [7:0]                      rsp_read_data;
   logic                            rsp_done_res;

   // Local copy of the panel registers and the frame contents.
   logic [mfb_pkg::CSR_DATA_W-1:0] cfg_width = mfb_pkg::PHYS_WIDTH_RST;
   logic [mfb_pkg::CSR_DATA_W-1:0] cfg_height = mfb_pkg::PHYS_HEIGHT_RST;
   logic                           cfg_portrait = 1'b0;
   logic [7:0]                     frame_model [FB_BYTES];

   fb_request_type request_q [$];
   logic [7:0]     expected_bytes [$];
   fb_request_type in_flight;
   int             issued = 0;
   int             results_seen = 0;
   int             fail_count = 0;
   int             cycle_count = 0;
   int             hold_ask = 0;
   int             hold_seen = 0;
   int             stall_left = 0;
   logic           steady = 1'b0;

   mono_framebuffer_rect_fill DUT (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
      .req_x_start(req_x_start), .req_x_end(req_x_end),
      .req_y_start(req_y_start), .req_y_end(req_y_end),
      .req_colour(req_colour), .req_byte_index(req_byte_index),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_read_data(rsp_read_data), .rsp_done_res(rsp_done_res)
   );

   always #5 clock = ~clock;

   function automatic int eff_dim(input logic [mfb_pkg::CSR_DATA_W-1:0] v);
      if (v == 0) return 1;
      if (v > PANEL_MAX) return PANEL_MAX;
      return int'(v);
   endfunction

   function automatic int clamp_coord(input int v, input int lim);
      return (v >= lim) ? lim - 1 : v;
   endfunction

   // Applies one request to the frame model and returns the byte the block should report.
   function automatic logic [7:0] apply_request(input fb_request_type r);
      int pw, ph, rowb, lw, lh, sx, ex, sy, ey, px, py, addr;
      logic [7:0] mask, rd;
      rd = '0;
      pw = eff_dim(cfg_width);
      ph = eff_dim(cfg_height);
      rowb = (pw + 7) / 8;
      if (r.kind == mfb_pkg::REQ_READ) begin
         if (r.byte_index < FB_BYTES) rd = frame_model[r.byte_index];
      end else begin
         lw = cfg_portrait ? ph : pw;
         lh = cfg_portrait ? pw : ph;
         sx = clamp_coord(int'(r.x_start), lw);
         ex = clamp_coord(int'(r.x_end), lw);
         sy = clamp_coord(int'(r.y_start), lh);
         ey = clamp_coord(int'(r.y_end), lh);
         for (int row = sy; row <= ey; row++) begin
            for (int col = sx; col <= ex; col++) begin
               if (cfg_portrait) begin
                  px = pw - 1 - row;
                  py = col;
               end else begin
                  px = col;
                  py = row;
               end
               addr = (ph - 1 - py) * rowb + px / 8;
               mask = mfb_pkg::PIX_MASK_MSB >> (px % 8);
               if (addr < FB_BYTES) begin
                  if (r.colour != 0) frame_model[addr] = frame_model[addr] | mask;
                  else frame_model[addr] = frame_model[addr] & ~mask;
               end
            end
         end
      end
      return rd;
   endfunction

   function automatic fb_request_type fill_req(input logic [7:0] xs, input logic [7:0] xe,
                                               input logic [7:0] ys, input logic [7:0] ye,
                                               input logic [15:0] c);
      fb_request_type r;
      r.kind = mfb_pkg::REQ_FILL;
      r.x_start = xs;
      r.x_end = xe;
      r.y_start = ys;
      r.y_end = ye;
      r.colour = c;
      r.byte_index = 13'($urandom);
      return r;
   endfunction

   function automatic fb_request_type read_req(input logic [12:0] idx);
      fb_request_type r;
      r.kind = mfb_pkg::REQ_READ;
      r.x_start = 8'($urandom);
      r.x_end = 8'($urandom);
      r.y_start = 8'($urandom);
      r.y_end = 8'($urandom);
      r.colour = 16'($urandom);
      r.byte_index = idx;
      return r;
   endfunction

   task automatic push_request(input fb_request_type r);
      request_q.push_back(r);
      issued++;
   endtask

   task automatic write_csr(input logic [mfb_pkg::CSR_INDEX_W-1:0] idx, input int val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[mfb_pkg::CSR_DATA_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         mfb_pkg::CSR_PHYS_WIDTH:  cfg_width = val[mfb_pkg::CSR_DATA_W-1:0];
         mfb_pkg::CSR_PHYS_HEIGHT: cfg_height = val[mfb_pkg::CSR_DATA_W-1:0];
         mfb_pkg::CSR_PORTRAIT:    cfg_portrait = val[0];
         default: ;
      endcase
   endtask

   // Returns once every issued transaction has produced its result and the block has settled.
   task automatic wait_drained();
      while (results_seen != issued) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // A short window that starts inside the given limit, clipped to the top of the 8-bit range.
   task automatic pick_window(input int lim, output logic [7:0] lo, output logic [7:0] hi);
      int a, b;
      a = $urandom_range(0, lim - 1);
      b = a + $urandom_range(0, 7);
      lo = 8'(a);
      hi = (b > 255) ? 8'd255 : 8'(b);
   endtask

   task automatic queue_random_requests(input int count);
      int pw, ph, lw, lh, used, mode, area;
      logic [7:0] xs, xe, ys, ye;
      logic [15:0] c;
      logic [12:0] idx;
      pw = eff_dim(cfg_width);
      ph = eff_dim(cfg_height);
      lw = cfg_portrait ? ph : pw;
      lh = cfg_portrait ? pw : ph;
      used = ((pw + 7) / 8) * ph;
      repeat (count) begin
         if ($urandom_range(0, 99) < 40) begin
            if ($urandom_range(0, 99) < 70) idx = 13'($urandom_range(0, used - 1));
            else idx = 13'($urandom);
            push_request(read_req(idx));
         end else begin
            mode = $urandom_range(0, 99);
            if (mode < 35) c = 16'h0000;
            else if (mode < 50) c = 16'h0001 << $urandom_range(0, 15);
            else c = 16'($urandom);
            mode = $urandom_range(0, 99);
            if (mode < 65) begin
               pick_window(lw, xs, xe);
               pick_window(lh, ys, ye);
            end else if (mode < 75) begin
               // Corners near or past the logical edge, so that clamping does the work.
               if ($urandom_range(0, 1)) begin
                  xs = 8'($urandom_range((lw > 4) ? lw - 4 : 0, 255));
                  xe = 8'($urandom_range(xs, 255));
                  pick_window(lh, ys, ye);
               end else begin
                  ys = 8'($urandom_range((lh > 4) ? lh - 4 : 0, 255));
                  ye = 8'($urandom_range(ys, 255));
                  pick_window(lw, xs, xe);
               end
            end else if (mode < 85) begin
               xs = 8'($urandom_range(1, 255));
               xe = 8'($urandom_range(0, xs - 1));
               pick_window(lh, ys, ye);
               if ($urandom_range(0, 1)) begin
                  {xs, xe, ys, ye} = {ys, ye, xe, xs};
               end
            end else begin
               // Fully random corners, redrawn while the clamped area stays large.
               do begin
                  xs = 8'($urandom);
                  xe = 8'($urandom);
                  ys = 8'($urandom);
                  ye = 8'($urandom);
                  area = (clamp_coord(int'(xe), lw) - clamp_coord(int'(xs), lw) + 1) *
                         (clamp_coord(int'(ye), lh) - clamp_coord(int'(ys), lh) + 1);
                  if (xs > xe || ys > ye) area = 0;
               end while (area > 1024);
            end
            push_request(fill_req(xs, xe, ys, ye, c));
         end
      end
   endtask

   // Request side: offers the next queued transaction, predicting each one as it is taken.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) expected_bytes.push_back(apply_request(in_flight));
         if (!req_valid || req_ready) begin
            if (request_q.size() != 0 && (steady || $urandom_range(0, 99) >= 16)) begin
               in_flight = request_q.pop_front();
               req_valid <= 1'b1;
               req_type <= in_flight.kind;
               req_x_start <= in_flight.x_start;
               req_x_end <= in_flight.x_end;
               req_y_start <= in_flight.y_start;
               req_y_end <= in_flight.y_end;
               req_colour <= in_flight.colour;
               req_byte_index <= in_flight.byte_index;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result side: checks each transaction against the oldest prediction and drives ready.
   always @(posedge clock) begin : rsp_side
      logic [7:0] want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (expected_bytes.size() == 0) begin
               $error("result with no request outstanding: read_data %0h", rsp_read_data);
               fail_count++;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_read_data !== want) begin
                  $error("read_data: expected %0h, got %0h", want, rsp_read_data);
                  fail_count++;
               end
               if (rsp_done_res !== 1'b1) begin
                  $error("done_res: expected 1, got %0b", rsp_done_res);
                  fail_count++;
               end
            end
         end
         if (hold_ask != hold_seen) begin
            hold_seen <= hold_ask;
            stall_left <= STALL_LEN;
            rsp_ready <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= steady || ($urandom_range(0, 99) >= 16);
         end
      end
   end

   initial begin
      int panel_w [10] = '{16, 1, 256, 0, 511, 13, 40, 256, 9, 200};
      int panel_h [10] = '{8, 1, 256, 511, 0, 21, 30, 256, 200, 9};
      int panel_p [10] = '{1, 0, 1, 1, 0, 1, 0, 0, 1, 0};
      foreach (frame_model[i]) frame_model[i] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset values of the panel registers; a write to the spare index must change nothing.
      write_csr(CSR_UNUSED, 511);
      push_request(read_req(13'd0));
      push_request(read_req(13'h1FFF));
      push_request(fill_req(8'd0, 8'd0, 8'd0, 8'd0, 16'h0001));
      push_request(read_req(13'd4975));
      push_request(fill_req(8'd255, 8'd255, 8'd255, 8'd255, 16'hFFFF));
      push_request(read_req(13'd24));
      push_request(fill_req(8'd9, 8'd3, 8'd0, 8'd0, 16'hFFFF));
      push_request(fill_req(8'd0, 8'd0, 8'd9, 8'd3, 16'hFFFF));
      push_request(fill_req(8'd0, 8'd15, 8'd0, 8'd1, 16'h8000));
      push_request(fill_req(8'd4, 8'd11, 8'd0, 8'd0, 16'h0000));
      push_request(read_req(13'd4975));
      push_request(read_req(13'd4976));
      push_request(read_req(13'd4950));
      queue_random_requests(PER_PHASE);
      wait_drained();

      for (int ph = 0; ph < 10; ph++) begin
         write_csr(mfb_pkg::CSR_PHYS_WIDTH, panel_w[ph]);
         write_csr(mfb_pkg::CSR_PHYS_HEIGHT, panel_h[ph]);
         write_csr(mfb_pkg::CSR_PORTRAIT, panel_p[ph]);
         steady = (ph == 5);
         if (panel_w[ph] == PANEL_MAX && panel_h[ph] == PANEL_MAX && panel_p[ph] == 1) begin
            // The one whole-panel fill at the largest size.
            push_request(fill_req(8'd0, 8'd255, 8'd0, 8'd255, 16'hFFFF));
            push_request(read_req(13'd0));
            push_request(read_req(13'h1FFF));
            push_request(fill_req(8'd0, 8'd255, 8'd100, 8'd100, 16'h0000));
         end
         queue_random_requests(PER_PHASE);
         // Hold results back while requests keep coming, so the block backs up.
         if (ph == 0) hold_ask++;
         wait_drained();
      end
      steady = 1'b0;

      if (expected_bytes.size() != 0) begin
         $error("%0d predicted results never arrived", expected_bytes.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
